// File: rtl/line_fit_gradient_descent_assert.svh
// Assertion macros shared by the line fit checker.
// Plain text only; included by files that assert.
`ifndef LINE_FIT_GRADIENT_DESCENT_ASSERT_SVH
`define LINE_FIT_GRADIENT_DESCENT_ASSERT_SVH
// implication checked on every clock edge outside reset
`define LFGD_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// implication checked also during reset
`define LFGD_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// File: rtl/lfgd_pkg.sv
// Package for the line fit block: widths, register indexes, helpers.
// No dependencies.
package lfgd_pkg;
	localparam int unsigned MaxPoints = 1024;
	localparam int unsigned CfgIdxW = 2;
	localparam logic [CfgIdxW-1:0] RegLearnRate = 2'd0;
	localparam logic [CfgIdxW-1:0] RegThreshold = 2'd1;
	localparam logic [CfgIdxW-1:0] RegMaxIter = 2'd2;
	localparam logic [31:0] LearnRateReset = 32'd429497;
	localparam logic [30:0] ThresholdReset = 31'd7;
	localparam logic [23:0] MaxIterReset = 24'hFFFFFF;
	localparam logic signed [31:0] SlopeInit = 32'sd65536;

	function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
		if (v > 80'sd2147483647) return 32'sh7FFFFFFF;
		else if (v < -80'sd2147483648) return 32'sh80000000;
		else return v[31:0];
	endfunction
endpackage

// File: rtl/lfgd_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module lfgd_ram #(
	parameter int unsigned Width = 32,
	parameter int unsigned Depth = 1024
) (
	input logic clk,
	input logic wr_en,
	input logic [$clog2(Depth)-1:0] wr_addr,
	input logic [Width-1:0] wr_data,
	input logic [$clog2(Depth)-1:0] rd_addr,
	output logic [Width-1:0] rd_data
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_data <= mem[rd_addr];
	end
endmodule

// File: rtl/lfgd_div.sv
// Restoring divider: 2^33 / n, one quotient bit per cycle.
// Uses nothing outside this file.
module lfgd_div #(
	parameter int unsigned CntW = 11
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [CntW-1:0] divisor,
	output logic busy,
	output logic [33:0] quotient
);
	logic [5:0] bit_q;
	logic [CntW:0] rem_q;
	logic [33:0] quo_q;
	logic [CntW+1:0] trial;
	logic nb;
	assign nb = (bit_q == 6'd34);
	assign trial = {rem_q, nb} - {2'b00, divisor};
	assign busy = (bit_q != 6'd0) || start;
	assign quotient = quo_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= '0;
		end else if (start) begin
			bit_q <= 6'd34;
		end else if (bit_q != 6'd0) begin
			bit_q <= bit_q - 6'd1;
		end
	end
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= '0;
		end else if (bit_q != 6'd0) begin
			if (!trial[CntW+1]) begin
				rem_q <= trial[CntW:0];
				quo_q <= {quo_q[32:0], 1'b1};
			end else begin
				rem_q <= {rem_q[CntW-1:0], nb};
				quo_q <= {quo_q[32:0], 1'b0};
			end
		end
	end
endmodule

// File: rtl/lfgd_mul.sv
// Shared signed 35x35 multiplier with a registered product.
// Uses nothing outside this file.
module lfgd_mul (
	input logic clk,
	input logic signed [34:0] a,
	input logic signed [34:0] b,
	output logic signed [69:0] p_q
);
	always_ff @(posedge clk) begin
		p_q <= a * b;
	end
endmodule

// File: rtl/line_fit_gradient_descent.sv
// Line fit by batch gradient descent: top level with point store and sequencer.
// Depends on lfgd_pkg, lfgd_ram, lfgd_div, lfgd_mul.
//
// Usage: points (x, y, last) arrive on the s_axis channel, one beat per cycle
// while loading; each is written into the point RAMs until they are full. A
// beat with tlast set starts the fit and s_axis_tready drops until the result is taken.
// The fit first runs a reciprocal divide of 2^33 by the point count, then
// each descent pass walks all stored points through one shared multiplier
// (read, slope times x, error, error times x, accumulate), followed by
// gradient scaling and weight update. The pass count is bounded by
// max_iterations. One result beat then appears on m_axis and is held until
// m_axis_tready; a stall there only delays the next set.
// Registers are to be written through the cfg channel only while the block
// is idle; the block itself does not enforce this.
// Reset (arst_n low) clears count, overflow flag, registers to defaults and
// all handshake state; the point RAMs are not cleared.
module line_fit_gradient_descent #(
	parameter int unsigned MAX_POINTS = lfgd_pkg::MaxPoints
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [63:0] s_axis_tdata, // x_value[31:0], y_value[63:32]
	input logic s_axis_tlast, // last_point
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// intercept[31:0], slope[63:32], iterations_used[87:64], converged[88],
	// capacity_overflow[89], zero fill [95:90]
	output logic [95:0] m_axis_tdata,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [lfgd_pkg::CfgIdxW-1:0] cfg_index,
	input logic [31:0] cfg_data
);
	localparam int unsigned AW = $clog2(MAX_POINTS);
	localparam int unsigned CW = $clog2(MAX_POINTS + 1);

	typedef enum logic [11:0] {
		ST_LOAD = 12'b000000000001,
		ST_DIV = 12'b000000000010,
		ST_RD = 12'b000000000100,
		ST_PM = 12'b000000001000,
		ST_PE = 12'b000000010000,
		ST_EM = 12'b000000100000,
		ST_ACC = 12'b000001000000,
		ST_G0 = 12'b000010000000,
		ST_G1 = 12'b000100000000,
		ST_U0 = 12'b001000000000,
		ST_U1 = 12'b010000000000,
		ST_OUT = 12'b100000000000
	} state_t;

	state_t st_q;
	logic [31:0] lr_q;
	logic [30:0] thr_q;
	logic [23:0] cap_q, iter_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] idx_q;
	logic ovf_q, conv_q;
	logic signed [31:0] w0_q, w1_q, g0_q, x_q, e_q, nb_q;
	logic signed [63:0] s0_q, s1_q;
	logic [33:0] r_q;
	logic [95:0] out_q;
	logic signed [34:0] ma, mb;
	logic signed [69:0] mp;
	logic [31:0] xr, yr;
	logic div_busy;
	logic [33:0] quo;
	logic in_acc, full;
	logic [1:0] gsub_q;
	logic signed [63:0] ghi_q;

	assign s_axis_tready = (st_q == ST_LOAD);
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign full = (cnt_q == CW'(MAX_POINTS));
	assign cfg_ready = 1'b1;
	assign m_axis_tvalid = (st_q == ST_OUT);
	assign m_axis_tdata = out_q;

	lfgd_ram #(.Width(32), .Depth(MAX_POINTS)) u_xram (
		.clk(clk), .wr_en(in_acc && !full), .wr_addr(cnt_q[AW-1:0]),
		.wr_data(s_axis_tdata[31:0]), .rd_addr(idx_q), .rd_data(xr));
	lfgd_ram #(.Width(32), .Depth(MAX_POINTS)) u_yram (
		.clk(clk), .wr_en(in_acc && !full), .wr_addr(cnt_q[AW-1:0]),
		.wr_data(s_axis_tdata[63:32]), .rd_addr(idx_q), .rd_data(yr));
	// divide runs after the last beat, so the count is already final
	lfgd_div #(.CntW(CW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(in_acc && s_axis_tlast),
		.divisor(cnt_q), .busy(div_busy), .quotient(quo));
	lfgd_mul u_mul (.clk(clk), .a(ma), .b(mb), .p_q(mp));

	// scaled gradient is formed in two multiplies: sum hi/lo halves times r
	logic [63:0] mag0;
	logic sneg;
	logic signed [63:0] ssel;
	assign ssel = (st_q == ST_G0) ? s0_q : s1_q;
	assign sneg = ssel[63];
	assign mag0 = sneg ? 64'(-ssel) : ssel;

	always_comb begin
		ma = '0;
		mb = '0;
		unique case (st_q)
			ST_PM: begin
				ma = 35'(signed'(w1_q));
				mb = 35'(signed'(xr));
			end
			ST_EM: begin
				ma = 35'(signed'(e_q));
				mb = 35'(signed'(x_q));
			end
			ST_G0, ST_G1: begin
				ma = signed'({3'b000, (gsub_q == 2'd0) ? mag0[63:32] : mag0[31:0]});
				mb = signed'({1'b0, r_q});
			end
			ST_U0, ST_U1: begin
				ma = signed'({3'b000, lr_q});
				mb = 35'(signed'((st_q == ST_U0) ? g0_q : nb_q));
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	logic signed [79:0] e_full, gq, gs, stepv, wnew;
	logic [63:0] qmag;
	logic signed [31:0] gsat, wsel;
	logic [31:0] gabs;
	logic gin;
	assign e_full = 80'(signed'(mp[63:16])) + 80'(w0_q) - 80'(signed'(yr));
	// q = hi*r + (lo*r >> 32), clamped to 2^50
	assign gq = 80'(ghi_q) + 80'(signed'({1'b0, mp[67:32]}));
	assign qmag = (gq > 80'sd1125899906842624) ? 64'd1125899906842624 : gq[63:0];
	assign gs = sneg ? -80'(signed'(qmag)) : 80'(signed'(qmag));
	assign gsat = lfgd_pkg::sat32(gs);
	assign gabs = gsat[31] ? 32'(-gsat) : gsat;
	assign gin = ($signed({1'b0, gabs}) <= $signed({2'b00, thr_q}));
	assign wsel = (st_q == ST_U0) ? w0_q : w1_q;
	// mp holds lr * g (signed); step = floor(lr*|g|/2^32) with g's sign
	assign stepv = mp[67] ? -80'(signed'({1'b0, 64'(-mp)} >>> 32))
		: 80'(signed'({1'b0, mp[63:0]} >>> 32));
	assign wnew = 80'(wsel) - stepv;

	logic signed [31:0] nm;
	logic cap_hit;
	assign nm = lfgd_pkg::sat32(wnew);
	assign cap_hit = (iter_q + 24'd1 >= ((cap_q == 24'd0) ? 24'd1 : cap_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_LOAD;
			lr_q <= lfgd_pkg::LearnRateReset;
			thr_q <= lfgd_pkg::ThresholdReset;
			cap_q <= lfgd_pkg::MaxIterReset;
			cnt_q <= '0;
			ovf_q <= 1'b0;
			idx_q <= '0;
			iter_q <= '0;
			gsub_q <= '0;
			conv_q <= 1'b0;
			w0_q <= '0;
			w1_q <= lfgd_pkg::SlopeInit;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					lfgd_pkg::RegLearnRate: lr_q <= cfg_data;
					lfgd_pkg::RegThreshold: thr_q <= cfg_data[30:0];
					lfgd_pkg::RegMaxIter: cap_q <= cfg_data[23:0];
					default: ;
				endcase
			end
			unique case (st_q)
				ST_LOAD: if (in_acc) begin
					if (full) ovf_q <= 1'b1;
					else cnt_q <= cnt_q + CW'(1);
					if (s_axis_tlast) begin
						st_q <= ST_DIV;
						w0_q <= '0;
						w1_q <= lfgd_pkg::SlopeInit;
						iter_q <= '0;
					end
				end
				ST_DIV: if (!div_busy) begin
					r_q <= quo;
					idx_q <= '0;
					s0_q <= '0;
					s1_q <= '0;
					st_q <= ST_RD;
				end
				ST_RD: st_q <= ST_PM;
				ST_PM: begin
					x_q <= xr;
					st_q <= ST_PE;
				end
				ST_PE: begin
					e_q <= lfgd_pkg::sat32(e_full);
					st_q <= ST_EM;
				end
				ST_EM: st_q <= ST_ACC;
				ST_ACC: begin
					s0_q <= s0_q + 64'(e_q);
					s1_q <= s1_q + 64'(signed'(mp[63:16]));
					if (32'(idx_q) + 32'd1 >= 32'(cnt_q)) begin
						st_q <= ST_G0;
						gsub_q <= '0;
					end else begin
						idx_q <= idx_q + AW'(1);
						st_q <= ST_RD;
					end
				end
				ST_G0, ST_G1: begin
					// gsub: 0 issue hi, 1 issue lo / latch hi, 2 hold, 3 combine
					if (gsub_q == 2'd0) gsub_q <= 2'd1;
					else if (gsub_q == 2'd1) begin
						ghi_q <= mp[63:0];
						gsub_q <= 2'd2;
					end else if (gsub_q == 2'd2) gsub_q <= 2'd3;
					else begin
						gsub_q <= '0;
						if (st_q == ST_G0) begin
							g0_q <= gsat;
							conv_q <= gin;
							st_q <= ST_G1;
						end else begin
							nb_q <= gsat;
							conv_q <= conv_q && gin;
							st_q <= ST_U0;
						end
					end
				end
				ST_U0: if (gsub_q == 2'd0) gsub_q <= 2'd1;
				else begin
					gsub_q <= '0;
					g0_q <= lfgd_pkg::sat32(wnew);
					st_q <= ST_U1;
				end
				ST_U1: if (gsub_q == 2'd0) gsub_q <= 2'd1;
				else begin
					gsub_q <= '0;
					w0_q <= g0_q;
					w1_q <= nm;
					iter_q <= iter_q + 24'd1;
					if (conv_q) st_q <= ST_OUT;
					else if ((g0_q == w0_q && nm == w1_q) || cap_hit) begin
						iter_q <= (cap_q == 24'd0) ? 24'd1 : cap_q;
						st_q <= ST_OUT;
					end else begin
						idx_q <= '0;
						s0_q <= '0;
						s1_q <= '0;
						st_q <= ST_RD;
					end
				end
				ST_OUT: if (m_axis_tready) begin
					st_q <= ST_LOAD;
					cnt_q <= '0;
					ovf_q <= 1'b0;
				end
				default: st_q <= ST_LOAD;
			endcase
		end
	end

	assign out_q = {6'd0, ovf_q, conv_q, iter_q, w1_q, w0_q};
endmodule

// File: rtl/lfgd_checker.sv
// Port-level checker for the line fit block, bound to the top level.
// Depends on line_fit_gradient_descent_assert.svh.
`include "line_fit_gradient_descent_assert.svh"
module lfgd_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic s_axis_tlast,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [95:0] m_axis_tdata
);
	`LFGD_ASSERT(a_busy_excl, clk, arst_n, m_axis_tvalid |-> !s_axis_tready, "input open with result pending")
	`LFGD_ASSERT(a_last_closes, clk, arst_n, (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready, "input open after last")
	`LFGD_ASSERT(a_hold, clk, arst_n, (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata), "result changed while stalled")
	`LFGD_ASSERT(a_fill, clk, arst_n, m_axis_tvalid |-> (m_axis_tdata[95:90] == 6'd0), "fill bits set")
	`LFGD_ASSERT_ALWAYS(a_rst, clk, $rose(arst_n) |-> !m_axis_tvalid, "result right out of reset")
endmodule

bind line_fit_gradient_descent lfgd_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .s_axis_tlast(s_axis_tlast),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata));
